>>> rtl/crd_pkg.sv
// Package for the cursor row decoder: sizes and the row request passed from
// the decode core to the output stage. No dependencies.
package crd_pkg;

  localparam int MAX_WIDTH  = 16;
  localparam int MAX_HEIGHT = 16;
  localparam int ROW_BITS   = 5;   // holds a row index up to MAX_HEIGHT
  localparam int COL_BITS   = 5;   // holds a column index up to MAX_WIDTH
  localparam int HALF_BITS  = 64;  // eight pixels of one half row

  typedef logic [MAX_WIDTH-1:0][7:0] row_pixels_t;

  // One row request from the core: a decoded row, or a zero flush that starts
  // at row and runs to the last image row.
  typedef struct packed {
    logic                valid;
    logic                flush;
    logic [ROW_BITS-1:0] row;
    row_pixels_t         pixels;
    logic [31:0]         hotspot;
  } row_req_t;

endpackage

>>> rtl/crd_if.sv
// Channel interfaces for the cursor row decoder: record bytes in, rows out.
// Depends on nothing.
interface crd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;

  modport source (output valid, output data_byte, output record_start, input ready);
  modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

interface crd_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         row_number;
  logic [63:0]        pixels_left_half;
  logic [63:0]        pixels_right_half;
  logic signed [15:0] hotspot_x;
  logic signed [15:0] hotspot_y;
  logic               final_row;

  modport source (output valid, output row_number, output pixels_left_half,
                  output pixels_right_half, output hotspot_x, output hotspot_y,
                  output final_row, input ready);
  modport sink   (input valid, input row_number, input pixels_left_half,
                  input pixels_right_half, input hotspot_x, input hotspot_y,
                  input final_row, output ready);
endinterface

>>> rtl/crd_core.sv
// Decode core: header, skip, plot and pixel phases, row buffer.
// Depends on crd_pkg.
module crd_core
  import crd_pkg::*;
#(
  parameter int IMAGE_WIDTH  = MAX_WIDTH,
  parameter int IMAGE_HEIGHT = MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       record_start,
  output row_req_t   req
);

  localparam logic [2:0] PH_DONE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_PLOT   = 3'd3;
  localparam logic [2:0] PH_PIXELS = 3'd4;

  localparam logic [COL_BITS-1:0] WIDTH_C  = COL_BITS'(IMAGE_WIDTH);
  localparam logic [ROW_BITS-1:0] HEIGHT_C = ROW_BITS'(IMAGE_HEIGHT);
  localparam logic [7:0]          WIDTH_B  = 8'(IMAGE_WIDTH);

  logic [2:0]          phase, phase_next, cur_phase;
  logic [1:0]          hdr_idx, hdr_idx_next;
  logic [31:0]         hotspot, hotspot_next;
  logic [ROW_BITS-1:0] row, row_next;
  logic [COL_BITS-1:0] col, col_next;
  logic [COL_BITS-1:0] remaining, remaining_next;
  logic [COL_BITS-1:0] room;
  row_pixels_t         pix, pix_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DONE;
      hdr_idx   <= '0;
      hotspot   <= '0;
      row       <= '0;
      col       <= '0;
      remaining <= '0;
      pix       <= '0;
    end else begin
      phase     <= phase_next;
      hdr_idx   <= hdr_idx_next;
      hotspot   <= hotspot_next;
      row       <= row_next;
      col       <= col_next;
      remaining <= remaining_next;
      pix       <= pix_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    hdr_idx_next   = hdr_idx;
    hotspot_next   = hotspot;
    row_next       = row;
    col_next       = col;
    remaining_next = remaining;
    pix_next       = pix;
    cur_phase      = phase;
    room           = '0;
    req            = '0;
    if (accept) begin
      // start flag restarts the record from any phase
      if (record_start) begin
        cur_phase      = PH_HEADER;
        hdr_idx_next   = '0;
        hotspot_next   = '0;
        row_next       = '0;
        col_next       = '0;
        remaining_next = '0;
        pix_next       = '0;
      end
      room = WIDTH_C - col_next;
      unique case (cur_phase)
        PH_DONE: begin
          phase_next = PH_DONE;
        end
        PH_HEADER: begin
          hotspot_next[{hdr_idx_next, 3'b000} +: 8] = data_byte;
          phase_next   = (hdr_idx_next == 2'd3) ? PH_SKIP : PH_HEADER;
          hdr_idx_next = hdr_idx_next + 2'd1;
        end
        PH_SKIP: begin
          if (data_byte >= WIDTH_B) begin
            req.valid   = 1'b1;
            req.flush   = 1'b1;
            req.row     = row_next;
            req.hotspot = hotspot_next;
            pix_next    = '0;
            phase_next  = PH_DONE;
          end else begin
            col_next   = data_byte[COL_BITS-1:0];
            phase_next = PH_PLOT;
          end
        end
        PH_PLOT: begin
          remaining_next = (data_byte < {3'b000, room}) ? data_byte[COL_BITS-1:0] : room;
          phase_next     = PH_PIXELS;
        end
        PH_PIXELS: begin
          pix_next[col_next[3:0]] = data_byte;
          col_next       = col_next + COL_BITS'(1);
          remaining_next = remaining_next - COL_BITS'(1);
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
      // row complete: zero plot count, or last pixel byte taken
      if ((cur_phase == PH_PLOT || cur_phase == PH_PIXELS) && remaining_next == '0) begin
        req.valid   = 1'b1;
        req.row     = row_next;
        req.pixels  = pix_next;
        req.hotspot = hotspot_next;
        pix_next    = '0;
        row_next    = row_next + ROW_BITS'(1);
        phase_next  = (row_next >= HEIGHT_C) ? PH_DONE : PH_SKIP;
      end
    end
  end

endmodule

>>> rtl/crd_out_stage.sv
// Output register and zero-row flush sequencer of the cursor row decoder.
// Depends on crd_pkg and crd_if.
module crd_out_stage
  import crd_pkg::*;
#(
  parameter int IMAGE_HEIGHT = MAX_HEIGHT
) (
  input  logic         clk,
  input  logic         rst,
  input  row_req_t     req,
  output logic         load_ok,
  crd_out_if.source    row_out
);

  localparam logic [ROW_BITS-1:0] LAST_ROW = ROW_BITS'(IMAGE_HEIGHT - 1);

  logic                out_valid;
  logic                flush_more;
  logic [ROW_BITS-1:0] flush_row;
  logic [3:0]          row_number;
  row_pixels_t         pixels;
  logic [31:0]         hotspot;
  logic                final_row;
  logic                slot_free;

  assign slot_free = !out_valid || row_out.ready;
  assign load_ok   = slot_free && !flush_more;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      flush_more <= 1'b0;
      flush_row  <= '0;
    end else if (slot_free) begin
      if (flush_more) begin
        out_valid  <= 1'b1;
        flush_more <= (flush_row != LAST_ROW);
        flush_row  <= flush_row + ROW_BITS'(1);
      end else if (req.valid) begin
        out_valid  <= 1'b1;
        flush_more <= req.flush && (req.row < LAST_ROW);
        flush_row  <= req.row + ROW_BITS'(1);
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (flush_more) begin
        row_number <= flush_row[3:0];
        pixels     <= '0;
        final_row  <= (flush_row >= LAST_ROW);
      end else if (req.valid) begin
        row_number <= req.row[3:0];
        pixels     <= req.flush ? '0 : req.pixels;
        hotspot    <= req.hotspot;
        final_row  <= (req.row >= LAST_ROW);
      end
    end
  end

  assign row_out.valid             = out_valid;
  assign row_out.row_number        = row_number;
  assign row_out.pixels_left_half  = pixels[7:0];
  assign row_out.pixels_right_half = pixels[15:8];
  assign row_out.hotspot_x         = hotspot[15:0];
  assign row_out.hotspot_y         = hotspot[31:16];
  assign row_out.final_row         = final_row;

endmodule

>>> rtl/cursor_row_rle_decoder.sv
// Cursor row run-length decoder, top level.
// Depends on crd_pkg, crd_if, crd_core and crd_out_stage.
//
// Usage:
//   byte_in  (sink)  : one record byte per beat; record_start marks the first
//                      byte (low byte of hotspot X) and restarts decoding.
//   row_out  (source): one 16-pixel row per beat with row number, hotspot and
//                      final_row on the last image row.
// Latency: a row appears on row_out the cycle after the byte that completes
//   it is accepted (one output register).
// Throughput: one byte per cycle while row_out keeps up. A skip count of
//   IMAGE_WIDTH or more flushes the remaining rows as zeros, one per cycle
//   while row_out keeps up; byte_in waits until the last zero row is loaded.
// Stall: with a row waiting and row_out.ready low, byte_in.ready drops;
//   nothing is lost or repeated.
// Reset (rst, synchronous): decoder is done and waits for a start byte; bytes
//   without record_start are dropped with no output. The output register is
//   emptied.
// Pixels never written in a row, and columns at or beyond IMAGE_WIDTH, are 0.
module cursor_row_rle_decoder
  import crd_pkg::*;
#(
  parameter int IMAGE_WIDTH  = MAX_WIDTH,
  parameter int IMAGE_HEIGHT = MAX_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  crd_in_if.sink    byte_in,
  crd_out_if.source row_out
);

  row_req_t req;
  logic     load_ok;
  logic     accept;

  // a byte is taken only when any row it may produce has a free slot
  assign byte_in.ready = load_ok;
  assign accept        = byte_in.valid && load_ok;

  crd_core #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (byte_in.data_byte),
    .record_start (byte_in.record_start),
    .req          (req)
  );

  crd_out_stage #(
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_out (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .load_ok (load_ok),
    .row_out (row_out)
  );

endmodule

>>> rtl/crd_checker.sv
// Port-level checks for the cursor row decoder, bound to the top level.
// Depends on crd_pkg.
module crd_checker
  import crd_pkg::*;
#(
  parameter int IMAGE_HEIGHT = MAX_HEIGHT
) (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] row_number,
  input logic       final_row
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("row beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("row beat right after reset");

  a_final_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && final_row |-> row_number == 4'(IMAGE_HEIGHT - 1))
    else $error("final_row on a row other than the last");

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("byte taken while a row is stalled");

endmodule

bind cursor_row_rle_decoder crd_checker #(
  .IMAGE_HEIGHT (IMAGE_HEIGHT)
) u_crd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (byte_in.ready),
  .out_valid  (row_out.valid),
  .out_ready  (row_out.ready),
  .row_number (row_out.row_number),
  .final_row  (row_out.final_row)
);

>>> tb/cursor_row_rle_decoder_checker.sv
// Scoreboard for the cursor row decoder: decodes each accepted record beat
// itself and compares every row beat field by field.
// Depends on crd_pkg and crd_if.
module cursor_row_rle_decoder_checker
  import crd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  crd_in_if    byte_in,
  crd_out_if   row_out,
  output int   mismatches,
  output int   rows_pending,
  output int   rows_seen,
  output int   records_seen,
  output int   early_ends
);

  localparam int WIDTH  = MAX_WIDTH;
  localparam int HEIGHT = MAX_HEIGHT;

  typedef enum logic [2:0] {DEC_IDLE, DEC_HEADER, DEC_SKIP, DEC_PLOT, DEC_PIXELS} dec_phase_t;

  typedef struct {
    logic [3:0]  row;
    logic [63:0] left;
    logic [63:0] right;
    logic [15:0] hot_x;
    logic [15:0] hot_y;
    logic        last;
  } cursor_row_t;

  cursor_row_t expected_rows[$];

  dec_phase_t   phase;
  logic [1:0]   hdr_idx;
  logic [31:0]  hotspot;      // X in 15:0, Y in 31:16
  logic [4:0]   cur_row;
  logic [4:0]   col;
  logic [4:0]   remaining;
  logic [127:0] row_buf;      // pixel n in bits 8n+7:8n

  task automatic clear_decoder();
    phase     = DEC_IDLE;
    hdr_idx   = '0;
    hotspot   = '0;
    cur_row   = '0;
    col       = '0;
    remaining = '0;
    row_buf   = '0;
  endtask

  task automatic queue_row(input logic [4:0] r, input logic [127:0] pix);
    cursor_row_t e;
    e.row   = r[3:0];
    e.left  = pix[63:0];
    e.right = pix[127:64];
    e.hot_x = hotspot[15:0];
    e.hot_y = hotspot[31:16];
    e.last  = (r >= HEIGHT - 1);
    expected_rows.push_back(e);
  endtask

  task automatic close_row();
    queue_row(cur_row, row_buf);
    row_buf = '0;
    cur_row = cur_row + 5'd1;
    phase   = (cur_row >= HEIGHT) ? DEC_IDLE : DEC_SKIP;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [4:0] room;
    if (start) begin
      clear_decoder();
      phase = DEC_HEADER;
      records_seen++;
    end
    case (phase)
      DEC_HEADER: begin
        hotspot[8*hdr_idx +: 8] = b;
        hdr_idx = hdr_idx + 2'd1;
        if (hdr_idx == 2'd0) phase = DEC_SKIP;
      end
      DEC_SKIP: begin
        if (b >= WIDTH) begin
          // early end: this row and the rest go out as zeros
          while (cur_row < HEIGHT) begin
            queue_row(cur_row, '0);
            cur_row = cur_row + 5'd1;
          end
          row_buf = '0;
          phase   = DEC_IDLE;
          early_ends++;
        end else begin
          col   = b[4:0];
          phase = DEC_PLOT;
        end
      end
      DEC_PLOT: begin
        room      = 5'(WIDTH) - col;
        remaining = (b < room) ? b[4:0] : room;
        if (remaining == 5'd0) close_row();
        else phase = DEC_PIXELS;
      end
      DEC_PIXELS: begin
        row_buf[8*col[3:0] +: 8] = b;
        col       = col + 5'd1;
        remaining = remaining - 5'd1;
        if (remaining == 5'd0) close_row();
      end
      default: phase = DEC_IDLE;   // done: beat dropped
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [3:0] r,
                             input logic [63:0] want, input logic [63:0] got);
    if (got !== want)
      report_mismatch($sformatf("row %0d %s: expected %h, got %h", r, name, want, got));
  endtask

  task automatic compare_row();
    cursor_row_t e;
    if (expected_rows.size() == 0) begin
      report_mismatch($sformatf("row beat %0d with nothing expected", row_out.row_number));
      return;
    end
    e = expected_rows.pop_front();
    rows_seen++;
    check_field("row_number", e.row, 64'(e.row), 64'(row_out.row_number));
    check_field("pixels_left_half", e.row, e.left, row_out.pixels_left_half);
    check_field("pixels_right_half", e.row, e.right, row_out.pixels_right_half);
    check_field("hotspot_x", e.row, 64'(e.hot_x), 64'($unsigned(row_out.hotspot_x)));
    check_field("hotspot_y", e.row, 64'(e.hot_y), 64'($unsigned(row_out.hotspot_y)));
    check_field("final_row", e.row, 64'(e.last), 64'(row_out.final_row));
  endtask

  // Rows leave through the output register after their byte, so the row beat
  // of this edge belongs to earlier bytes: check it before decoding the new byte.
  always @(posedge clk) begin
    if (rst) begin
      clear_decoder();
      expected_rows.delete();
    end else begin
      if (row_out.valid && row_out.ready) compare_row();
      if (byte_in.valid && byte_in.ready) decode_byte(byte_in.data_byte, byte_in.record_start);
    end
    rows_pending <= expected_rows.size();
  end

endmodule

>>> tb/cursor_row_rle_decoder_tb.sv
// Testbench top for the cursor row decoder: clock, reset, record stimulus,
// row sink with stalls, and the verdict. Depends on crd_pkg, crd_if, the
// decoder RTL and cursor_row_rle_decoder_checker.
module cursor_row_rle_decoder_tb;
  import crd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  crd_in_if  byte_ch ();
  crd_out_if row_ch ();

  int mismatches;
  int rows_pending;
  int rows_seen;
  int records_seen;
  int early_ends;
  int bytes_sent;

  bit no_idle;        // both sides run without gaps while set
  bit hold_rows;      // asks the row sink for one long hold-off

  logic [7:0] rec_q[$];  // bytes of the record being sent

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cursor_row_rle_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_ch),
    .row_out (row_ch)
  );

  cursor_row_rle_decoder_checker chk (
    .clk          (clk),
    .rst          (rst),
    .byte_in      (byte_ch),
    .row_out      (row_ch),
    .mismatches   (mismatches),
    .rows_pending (rows_pending),
    .rows_seen    (rows_seen),
    .records_seen (records_seen),
    .early_ends   (early_ends)
  );

  // ---------------------------------------------------------------------
  // Byte side. One beat per call: optional idle gap, then hold valid until
  // the decoder takes it. Valid stays high across back-to-back beats.
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic first, input bit counted);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.data_byte    <= b;
    byte_ch.record_start <= first;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    if (counted) bytes_sent++;
  endtask

  // Send the first count bytes of rec_q; only byte 0 carries the start flag.
  task automatic send_record(input int count);
    for (int i = 0; i < count; i++) send_byte(rec_q[i], i == 0, 1'b1);
  endtask

  // Stop offering bytes and wait until every predicted row has been seen.
  // The first edge lets the checker's pending count catch up with the last
  // accepted byte.
  task automatic drain_rows();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
  endtask

  // Hotspots lean on the signed extremes so both sign cases and every bit
  // show up early.
  function automatic logic [15:0] pick_hotspot();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Well-formed record with random content. Plot counts are mostly small so
  // records stay short and many rows finish; now and then a plot overruns
  // the row, and about one record in four ends early with a large skip.
  task automatic build_record();
    logic [15:0] hx;
    logic [15:0] hy;
    int stop_row;
    int skip;
    int plot;
    int npix;
    hx = pick_hotspot();
    hy = pick_hotspot();
    rec_q.delete();
    rec_q.push_back(hx[7:0]);
    rec_q.push_back(hx[15:8]);
    rec_q.push_back(hy[7:0]);
    rec_q.push_back(hy[15:8]);
    stop_row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_HEIGHT - 1) : MAX_HEIGHT;
    for (int r = 0; r < MAX_HEIGHT; r++) begin
      if (r == stop_row) begin
        rec_q.push_back(($urandom_range(0, 1) == 0) ? 8'(MAX_WIDTH)
                                                    : 8'($urandom_range(MAX_WIDTH, 255)));
        break;
      end
      skip = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_WIDTH - 1);
      plot = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
      npix = (plot < MAX_WIDTH - skip) ? plot : MAX_WIDTH - skip;
      rec_q.push_back(8'(skip));
      rec_q.push_back(8'(plot));
      repeat (npix) rec_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Row side. Per beat an optional random stall, or one long hold-off on
  // request; ready then stays high until a row is taken.
  // ---------------------------------------------------------------------
  initial begin
    int stall;
    row_ch.ready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_rows) begin
        hold_rows = 1'b0;
        stall     = 80;   // long enough for the output register to fill and
                          // the byte side to back up
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (stall != 0) begin
        row_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      row_ch.ready <= 1'b1;
      @(posedge clk);
      while (!row_ch.valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and verdict.
  // ---------------------------------------------------------------------
  initial begin
    int iter;
    int pick;
    int cut;
    byte_ch.valid        <= 1'b0;
    byte_ch.data_byte    <= 8'h00;
    byte_ch.record_start <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Decoder comes out of reset done: unflagged bytes are dropped.
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);

    // Hotspot X = -32768, Y = +32767.
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h7F, 1'b0, 1'b1);
    // Row 0: zero plot, emitted on the plot byte.
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    // Row 1: skip 15, plot 255 clipped to one pixel in the last column.
    send_byte(8'h0F, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hAB, 1'b0, 1'b1);
    // Row 2: two pixels at the left edge, 00 then FF.
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h02, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    // Skip of exactly the width: rows 3..15 flushed as zeros.
    send_byte(8'(MAX_WIDTH), 1'b0, 1'b1);
    // Trailing byte after completion, dropped.
    send_byte(8'h55, 1'b0, 1'b0);

    // Restart in the middle of a header, then hotspot -1/-1 and skip 255 on
    // row 0: all sixteen rows come out of one byte.
    send_byte(8'h12, 1'b1, 1'b1);
    send_byte(8'h34, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    drain_rows();

    // Random records. Most are complete; some are cut short and restarted by
    // the next start flag, and some are followed by stray bytes the decoder
    // must drop. Every fifth record the sender waits for all rows first.
    iter = 0;
    while (bytes_sent < 250 || rows_seen < 60) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (iter == 2) begin
        hold_rows = 1'b1;
        no_idle   = 1'b1;
      end
      if (iter % 5 == 4) drain_rows();
      build_record();
      pick = $urandom_range(0, 9);
      if (pick == 7 || pick == 8) begin
        cut = $urandom_range(1, rec_q.size() - 1);
        send_record(cut);
      end else begin
        send_record(rec_q.size());
        if (pick == 9)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      iter++;
    end

    drain_rows();
    repeat (10) @(posedge clk);   // room for any stray row beat to show up

    $display("Decoded %0d records (%0d ended early with zero rows) from %0d bytes,",
             records_seen, early_ends, bytes_sent);
    $display("checked %0d rows with random gaps, stalls and one long row hold-off.",
             rows_seen);
    if (mismatches == 0 && rows_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timeout with %0d rows still expected", rows_pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
